>>> rtl/iwf_pkg.sv
// ----------------------------------------------------------------------------
// iwf_pkg
// shared constants, register indexes and helpers of the indenter/wall
// force core
// ----------------------------------------------------------------------------
package iwf_pkg;

  localparam int unsigned MaxAtoms = 1048576;
  localparam int unsigned CntW     = 21;
  localparam logic [CntW-1:0] CntCap =
    (MaxAtoms < 2097151) ? CntW'(MaxAtoms) : CntW'(2097151);

  localparam logic [47:0] AccMax = 48'hFFFF_FFFF_FFFF;
  localparam logic [46:0] MCap   = 47'h7FFF_FFFF_FFFF;

  // configuration register indexes
  localparam logic [2:0] RegIsWall   = 3'd0;
  localparam logic [2:0] RegCenterX  = 3'd1;
  localparam logic [2:0] RegCenterY  = 3'd2;
  localparam logic [2:0] RegCenterZ  = 3'd3;
  localparam logic [2:0] RegDirCode  = 3'd4;
  localparam logic [2:0] RegCutoff   = 3'd5;
  localparam logic [2:0] RegStrength = 3'd6;

  localparam logic [2:0]  DirReset      = 3'd4;
  localparam logic [30:0] CutoffReset   = 31'd65536;
  localparam logic [30:0] StrengthReset = 31'd65536;
  localparam logic signed [31:0] LowReset = 32'sh7FFF_FFFF;

  // signed 32-bit pattern of a magnitude, saturated
  function automatic logic [31:0] sat_out(logic [63:0] mag, logic neg);
    logic [31:0] r;
    if (neg) begin
      if (mag > 64'h8000_0000) r = 32'h8000_0000;
      else                     r = 32'd0 - mag[31:0];
    end else begin
      if (mag > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
      else                     r = mag[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/indenter_wall_force_core.sv
// ----------------------------------------------------------------------------
// indenter_wall_force_core
// harmonic force from one spherical indenter or flat wall on one atom per
// beat, with per-frame normal-force sum, contact count and contact extent
// ----------------------------------------------------------------------------
// One atom is handled at a time by a sequencer around a single 32x32
// multiplier, a one-bit-per-cycle square root and a one-bit-per-cycle
// restoring divider. An indenter atom in contact goes through accept, check,
// 3 squares, 32 root steps, test, 3 product steps, then per axis 48 divide
// steps and 2 product steps, then finish; a wall atom in contact through
// accept, check, 3 product steps, 64 divide steps and finish; an atom out of
// contact goes to finish from the check or, for an indenter, from the test.
// The divider dominates. Input ready is high only while the sequencer is
// idle; a finished result sits in the output register until taken, and the
// sequencer waits in its finish step while that register is still full.
module indenter_wall_force_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] atom_x_i,
  input  logic signed [31:0] atom_y_i,
  input  logic signed [31:0] atom_z_i,
  input  logic               new_frame_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] force_x_o,
  output logic signed [31:0] force_y_o,
  output logic signed [31:0] force_z_o,
  output logic               in_contact_o,
  output logic               zero_distance_fault_o,
  output logic [47:0]        normal_force_sum_o,
  output logic [20:0]        contact_count_o,
  output logic signed [31:0] span_a_min_o,
  output logic signed [31:0] span_a_max_o,
  output logic signed [31:0] span_b_min_o,
  output logic signed [31:0] span_b_max_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SQ, S_SQRT, S_TEST, S_DDT, S_MLO, S_MHI,
    S_DIV, S_GLO, S_GHI, S_FIN
  } state_e;

  // configuration
  logic               is_wall_q;
  logic signed [31:0] center_x_q, center_y_q, center_z_q;
  logic [2:0]         dir_q;
  logic [30:0]        rc_q, strength_q;

  // frame state
  logic [47:0]        acc_q;
  logic [20:0]        cnt_q;
  logic signed [31:0] a_lo_q, a_hi_q, b_lo_q, b_hi_q;

  // working registers
  state_e             state_q;
  logic signed [31:0] pos_q [3];
  logic [32:0]        ad_q [3];
  logic [2:0]         dpos_q;
  logic [1:0]         k_q;
  logic [63:0]        sx_q;
  logic [35:0]        sq_rem_q;
  logic [31:0]        root_q;
  logic [6:0]         it_q;
  logic [31:0]        d1_q;
  logic [30:0]        dd_q;
  logic [45:0]        t_q;
  logic [63:0]        plo_q;
  logic [46:0]        m_q;
  logic [63:0]        dvd_q;
  logic [31:0]        drem_q;
  logic [16:0]        quo_q;
  logic [31:0]        fo_q [3];
  logic [63:0]        normal_q;
  logic               contact_q, fault_q;

  // output registers
  logic               ov_q;
  logic signed [31:0] fx_oq, fy_oq, fz_oq;
  logic               ic_oq, zf_oq;
  logic [47:0]        nfs_oq;
  logic [20:0]        cc_oq;
  logic signed [31:0] amin_oq, amax_oq, bmin_oq, bmax_oq;

  logic [1:0] axis;
  logic       dneg;
  assign axis = (dir_q[2:1] > 2'd2) ? 2'd2 : dir_q[2:1];
  assign dneg = dir_q[0];

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ:    begin mul_a = ad_q[k_q][31:0]; mul_b = ad_q[k_q][31:0]; end
      S_DDT:   begin mul_a = {1'b0, strength_q}; mul_b = {1'b0, rc_q - d1_q[30:0]}; end
      S_MLO:   begin mul_a = t_q[31:0]; mul_b = {1'b0, dd_q}; end
      S_MHI:   begin mul_a = {18'd0, t_q[45:32]}; mul_b = {1'b0, dd_q}; end
      S_GLO:   begin mul_a = m_q[31:0]; mul_b = {15'd0, quo_q}; end
      S_GHI:   begin mul_a = {17'd0, m_q[46:32]}; mul_b = {15'd0, quo_q}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  // square root step
  logic [35:0] rs_sh, rs_trial;
  logic        rs_ge;
  assign rs_sh    = {sq_rem_q[33:0], sx_q[63:62]};
  assign rs_trial = {2'b00, root_q, 2'b01};
  assign rs_ge    = rs_sh >= rs_trial;

  // divider step
  logic [32:0] dv_sh;
  logic        dv_ge;
  assign dv_sh = {drem_q, dvd_q[63]};
  assign dv_ge = dv_sh >= {1'b0, d1_q};

  // harmonic magnitude, then saturated
  logic [77:0] m_sum;
  logic [46:0] m_sat;
  assign m_sum = {14'd0, plo_q} + {prod[45:0], 32'd0};
  assign m_sat = (m_sum[77:16] > {15'd0, iwf_pkg::MCap}) ? iwf_pkg::MCap : m_sum[62:16];

  // per-axis force magnitude
  logic [64:0] g_sum;
  logic [47:0] g_mag;
  assign g_sum = {1'b0, plo_q} + {1'b0, prod[31:0], 32'd0};
  assign g_mag = g_sum[63:16];

  // frame state after this atom
  logic [64:0]        acc_sum;
  logic [47:0]        acc_n;
  logic [20:0]        cnt_n;
  logic signed [31:0] ca, cb, a_lo_n, a_hi_n, b_lo_n, b_hi_n;
  always_comb begin
    acc_sum = {17'd0, acc_q} + {1'b0, normal_q};
    acc_n   = acc_q;
    cnt_n   = cnt_q;
    ca      = (axis == 2'd0) ? pos_q[1] : pos_q[0];
    cb      = (axis == 2'd2) ? pos_q[1] : pos_q[2];
    a_lo_n  = a_lo_q;
    a_hi_n  = a_hi_q;
    b_lo_n  = b_lo_q;
    b_hi_n  = b_hi_q;
    if (contact_q) begin
      acc_n = (acc_sum > {17'd0, iwf_pkg::AccMax}) ? iwf_pkg::AccMax : acc_sum[47:0];
      if (cnt_q < iwf_pkg::CntCap) cnt_n = cnt_q + 21'd1;
      if (!is_wall_q) begin
        if (ca > a_hi_q) a_hi_n = ca;
        if (ca < a_lo_q) a_lo_n = ca;
        if (cb > b_hi_q) b_hi_n = cb;
        if (cb < b_lo_q) b_lo_n = cb;
      end
    end
  end

  logic signed [32:0] dn [3];
  logic signed [31:0] cen [3];
  logic signed [31:0] ain [3];
  assign cen[0] = center_x_q;
  assign cen[1] = center_y_q;
  assign cen[2] = center_z_q;
  assign ain[0] = atom_x_i;
  assign ain[1] = atom_y_i;
  assign ain[2] = atom_z_i;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dn[i] = 33'(cen[i]) - 33'(ain[i]);
    end
  end

  logic [32:0] ad_ax;
  assign ad_ax = ad_q[axis];

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_wall_q  <= 1'b0;
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      dir_q      <= iwf_pkg::DirReset;
      rc_q       <= iwf_pkg::CutoffReset;
      strength_q <= iwf_pkg::StrengthReset;
      acc_q      <= '0;
      cnt_q      <= '0;
      a_lo_q     <= iwf_pkg::LowReset;
      b_lo_q     <= iwf_pkg::LowReset;
      a_hi_q     <= '0;
      b_hi_q     <= '0;
      state_q    <= S_IDLE;
      ov_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          iwf_pkg::RegIsWall:   is_wall_q  <= cfg_data_i[0];
          iwf_pkg::RegCenterX:  center_x_q <= cfg_data_i;
          iwf_pkg::RegCenterY:  center_y_q <= cfg_data_i;
          iwf_pkg::RegCenterZ:  center_z_q <= cfg_data_i;
          iwf_pkg::RegDirCode:  dir_q      <= cfg_data_i[2:0];
          iwf_pkg::RegCutoff:   rc_q       <= cfg_data_i[30:0];
          iwf_pkg::RegStrength: strength_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (state_q == S_FIN && (!ov_q || out_ready_i)) ov_q <= 1'b1;
      else if (out_ready_i)                           ov_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            for (int i = 0; i < 3; i++) begin
              pos_q[i]  <= ain[i];
              ad_q[i]   <= dn[i][32] ? 33'd0 - dn[i] : dn[i];
              dpos_q[i] <= !dn[i][32] && (dn[i] != 33'sd0);
            end
            if (new_frame_i) begin
              acc_q  <= '0;
              cnt_q  <= '0;
              a_lo_q <= iwf_pkg::LowReset;
              b_lo_q <= iwf_pkg::LowReset;
              a_hi_q <= '0;
              b_hi_q <= '0;
            end
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          for (int i = 0; i < 3; i++) fo_q[i] <= '0;
          normal_q  <= '0;
          contact_q <= 1'b0;
          fault_q   <= 1'b0;
          if (is_wall_q) begin
            if (ad_ax < {2'b00, rc_q}) begin
              if (ad_ax == 33'd0) begin
                fault_q <= 1'b1;
                state_q <= S_FIN;
              end else begin
                d1_q    <= ad_ax[31:0];
                state_q <= S_DDT;
              end
            end else begin
              state_q <= S_FIN;
            end
          end else if (ad_q[0] < {2'b00, rc_q} && ad_q[1] < {2'b00, rc_q} &&
                       ad_q[2] < {2'b00, rc_q}) begin
            sx_q    <= '0;
            k_q     <= 2'd0;
            state_q <= S_SQ;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_SQ: begin
          sx_q <= sx_q + prod;
          if (k_q == 2'd2) begin
            sq_rem_q <= '0;
            root_q   <= '0;
            it_q     <= 7'd31;
            state_q  <= S_SQRT;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        S_SQRT: begin
          sq_rem_q <= rs_ge ? rs_sh - rs_trial : rs_sh;
          root_q   <= {root_q[30:0], rs_ge};
          sx_q     <= {sx_q[61:0], 2'b00};
          if (it_q == 7'd0) state_q <= S_TEST;
          else              it_q <= it_q - 7'd1;
        end
        S_TEST: begin
          if (root_q < {1'b0, rc_q}) begin
            if (root_q == 32'd0) begin
              fault_q <= 1'b1;
              state_q <= S_FIN;
            end else begin
              d1_q    <= root_q;
              state_q <= S_DDT;
            end
          end else begin
            state_q <= S_FIN;
          end
        end
        S_DDT: begin
          dd_q    <= rc_q - d1_q[30:0];
          t_q     <= prod[61:16];
          state_q <= S_MLO;
        end
        S_MLO: begin
          plo_q   <= prod;
          state_q <= S_MHI;
        end
        S_MHI: begin
          m_q    <= m_sat;
          drem_q <= '0;
          if (is_wall_q) begin
            dvd_q <= {1'b0, m_sat, 16'd0};
            it_q  <= 7'd63;
          end else begin
            dvd_q <= {ad_q[0][31:0], 32'd0};
            it_q  <= 7'd47;
            k_q   <= 2'd0;
          end
          state_q <= S_DIV;
        end
        S_DIV: begin
          drem_q <= dv_ge ? 32'(dv_sh - {1'b0, d1_q}) : dv_sh[31:0];
          dvd_q  <= {dvd_q[62:0], dv_ge};
          if (it_q == 7'd0) begin
            if (is_wall_q) begin
              fo_q[axis] <= iwf_pkg::sat_out({dvd_q[62:0], dv_ge}, dneg);
              normal_q   <= {dvd_q[62:0], dv_ge};
              contact_q  <= 1'b1;
              state_q    <= S_FIN;
            end else begin
              quo_q   <= {dvd_q[15:0], dv_ge};
              state_q <= S_GLO;
            end
          end else begin
            it_q <= it_q - 7'd1;
          end
        end
        S_GLO: begin
          plo_q   <= prod;
          state_q <= S_GHI;
        end
        S_GHI: begin
          fo_q[k_q] <= iwf_pkg::sat_out({16'd0, g_mag}, dpos_q[k_q]);
          if (k_q == axis) normal_q <= {16'd0, g_mag};
          if (k_q == 2'd2) begin
            contact_q <= 1'b1;
            state_q   <= S_FIN;
          end else begin
            k_q     <= k_q + 2'd1;
            dvd_q   <= {ad_q[k_q + 2'd1][31:0], 32'd0};
            drem_q  <= '0;
            it_q    <= 7'd47;
            state_q <= S_DIV;
          end
        end
        S_FIN: begin
          if (!ov_q || out_ready_i) begin
            acc_q   <= acc_n;
            cnt_q   <= cnt_n;
            a_lo_q  <= a_lo_n;
            a_hi_q  <= a_hi_n;
            b_lo_q  <= b_lo_n;
            b_hi_q  <= b_hi_n;
            fx_oq   <= fo_q[0];
            fy_oq   <= fo_q[1];
            fz_oq   <= fo_q[2];
            ic_oq   <= contact_q;
            zf_oq   <= fault_q;
            nfs_oq  <= acc_n;
            cc_oq   <= cnt_n;
            amin_oq <= a_lo_n;
            amax_oq <= a_hi_n;
            bmin_oq <= b_lo_n;
            bmax_oq <= b_hi_n;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o           = ov_q;
  assign force_x_o             = fx_oq;
  assign force_y_o             = fy_oq;
  assign force_z_o             = fz_oq;
  assign in_contact_o          = ic_oq;
  assign zero_distance_fault_o = zf_oq;
  assign normal_force_sum_o    = nfs_oq;
  assign contact_count_o       = cc_oq;
  assign span_a_min_o          = amin_oq;
  assign span_a_max_o          = amax_oq;
  assign span_b_min_o          = bmin_oq;
  assign span_b_max_o          = bmax_oq;

endmodule
